@@ rtl/core/abg_pkg.sv @@
// Shared constants for the alpha-beta-gamma tracker: widths, defaults and register indexes.
package abg_pkg;

	localparam int VALUE_WIDTH_DEFAULT   = 32;
	localparam int FRACTION_BITS_DEFAULT = 16;

	localparam int REG_W       = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CHUNK_W     = 24;
	localparam int CAP_LOG2    = 60;

	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD       = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD_SQUARED = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_GAIN          = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_BETA_GAIN           = CFG_INDEX_W'(3);
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_GAIN          = CFG_INDEX_W'(4);

endpackage

@@ rtl/core/alpha_beta_gamma_tracker_unit.sv @@
// Alpha-beta-gamma tracking filter with one shared gain multiplier under a small sequencer.
// Each input transfer carries one position sample; the block predicts position and velocity,
// corrects position, velocity and acceleration by the residual, and returns the corrected
// position as one output transfer. All six gain products go through a single 24-bit by
// 24-bit multiplier, each product in two halves, after a magnitude step and followed by
// rounding, accumulate and saturate steps. The input is stalled from the input transfer
// until the result is loaded into the output register, so the block takes no new sample
// before it is through with the last one. A result that is still waiting in the output
// register does not stop the next sample from being accepted and worked on; that sample
// only holds at its final step until the output register is free.
module alpha_beta_gamma_tracker_unit #(
	parameter int VALUE_WIDTH   = abg_pkg::VALUE_WIDTH_DEFAULT,
	parameter int FRACTION_BITS = abg_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [abg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [abg_pkg::REG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [VALUE_WIDTH-1:0]        sample,
	input  logic                                 last_in_sequence,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [VALUE_WIDTH-1:0]        filtered_position
);

	localparam int REG_W   = abg_pkg::REG_W;
	localparam int CHUNK_W = abg_pkg::CHUNK_W;
	localparam int MAG_W   = VALUE_WIDTH + 1;
	localparam int HI_W    = (MAG_W > CHUNK_W) ? MAG_W - CHUNK_W : 1;
	localparam int MA_W    = (HI_W > CHUNK_W) ? HI_W : CHUNK_W;
	localparam int PROD_W  = MA_W + REG_W;
	localparam int FULL_W  = MAG_W + REG_W + 1;
	localparam int CAP_W   = abg_pkg::CAP_LOG2 + 1;
	localparam int CMP_W   = (FULL_W > CAP_W) ? FULL_W : CAP_W;
	localparam int ACC_W   = CAP_W + 2;

	localparam logic [REG_W-1:0] PERIOD_RESET = REG_W'(64'd1 << FRACTION_BITS);
	localparam logic [REG_W-1:0] HALF_RESET   = REG_W'(64'd1 << (FRACTION_BITS - 1));

	localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (VALUE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic [FULL_W-1:0]       ROUND_HALF = FULL_W'(1) << (FRACTION_BITS - 1);
	localparam logic [CMP_W-1:0]        CAP_CMP = CMP_W'(1) << abg_pkg::CAP_LOG2;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_VT = 3'd0;
	localparam logic [OP_W-1:0] OP_AH = 3'd1;
	localparam logic [OP_W-1:0] OP_AT = 3'd2;
	localparam logic [OP_W-1:0] OP_PA = 3'd3;
	localparam logic [OP_W-1:0] OP_VB = 3'd4;
	localparam logic [OP_W-1:0] OP_AG = 3'd5;

	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_ABS = 3'd0;
	localparam logic [PH_W-1:0] PH_MLO = 3'd1;
	localparam logic [PH_W-1:0] PH_MHI = 3'd2;
	localparam logic [PH_W-1:0] PH_SUM = 3'd3;
	localparam logic [PH_W-1:0] PH_ACC = 3'd4;
	localparam logic [PH_W-1:0] PH_SAT = 3'd5;

	logic [REG_W-1:0] period_q;
	logic [REG_W-1:0] half_q;
	logic [REG_W-1:0] alpha_q;
	logic [REG_W-1:0] beta_q;
	logic [REG_W-1:0] accel_q;

	logic signed [VALUE_WIDTH-1:0] p_q;
	logic signed [VALUE_WIDTH-1:0] v_q;
	logic signed [VALUE_WIDTH-1:0] a_q;

	logic            busy_q;
	logic [OP_W-1:0] op_q;
	logic [PH_W-1:0] ph_q;
	logic            out_valid_q;

	logic                          last_q;
	logic signed [VALUE_WIDTH-1:0] x_q;
	logic signed [VALUE_WIDTH-1:0] pp_q;
	logic signed [VALUE_WIDTH-1:0] pv_q;
	logic signed [VALUE_WIDTH-1:0] out_q;
	logic signed [MAG_W-1:0]       r_q;
	logic [MAG_W-1:0]              opm_q;
	logic                          neg_q;
	logic [PROD_W-1:0]             prod_q;
	logic [FULL_W-1:0]             part_q;
	logic [CAP_W-1:0]              mag_q;
	logic signed [ACC_W-1:0]       acc_q;

	logic                          accept;
	logic                          out_free;
	logic signed [MAG_W-1:0]       src;
	logic [MAG_W-1:0]              src_mag;
	logic [REG_W-1:0]              gain_sel;
	logic [CHUNK_W-1:0]            lo_chunk;
	logic [HI_W-1:0]               hi_chunk;
	logic [MA_W-1:0]               mul_a;
	logic [PROD_W-1:0]             mul_p;
	logic [FULL_W-1:0]             full_sum;
	logic [CMP_W-1:0]              shifted;
	logic [CAP_W-1:0]              mag_next;
	logic signed [ACC_W-1:0]       mag_ext;
	logic signed [ACC_W-1:0]       acc_sum;
	logic signed [VALUE_WIDTH-1:0] sat_val;
	logic signed [MAG_W-1:0]       r_next;

	assign accept   = in_valid && !busy_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (op_q)
			OP_VT: begin
				src      = MAG_W'(v_q);
				gain_sel = period_q;
			end
			OP_AH: begin
				src      = MAG_W'(a_q);
				gain_sel = half_q;
			end
			OP_AT: begin
				src      = MAG_W'(a_q);
				gain_sel = period_q;
			end
			OP_PA: begin
				src      = r_q;
				gain_sel = alpha_q;
			end
			OP_VB: begin
				src      = r_q;
				gain_sel = beta_q;
			end
			default: begin
				src      = r_q;
				gain_sel = accel_q;
			end
		endcase
	end

	assign src_mag  = src[MAG_W-1] ? MAG_W'(-src) : MAG_W'(src);
	assign lo_chunk = CHUNK_W'(opm_q);
	assign hi_chunk = HI_W'(opm_q >> CHUNK_W);
	assign mul_a    = (ph_q == PH_MLO) ? MA_W'(lo_chunk) : MA_W'(hi_chunk);
	assign mul_p    = PROD_W'(mul_a) * PROD_W'(gain_sel);

	assign full_sum = (FULL_W'(prod_q) << CHUNK_W) + part_q;
	assign shifted  = CMP_W'(full_sum >> FRACTION_BITS);
	assign mag_next = (shifted > CAP_CMP) ? CAP_W'(CAP_CMP) : CAP_W'(shifted);

	assign mag_ext = ACC_W'(mag_q);
	assign acc_sum = neg_q ? acc_q - mag_ext : acc_q + mag_ext;

	assign sat_val = (acc_q > SAT_HI) ? VALUE_WIDTH'(SAT_HI) :
		(acc_q < SAT_LO) ? VALUE_WIDTH'(SAT_LO) : VALUE_WIDTH'(acc_q);

	assign r_next = MAG_W'(x_q) - MAG_W'(pp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			half_q      <= HALF_RESET;
			alpha_q     <= '0;
			beta_q      <= '0;
			accel_q     <= '0;
			p_q         <= '0;
			v_q         <= '0;
			a_q         <= '0;
			busy_q      <= 1'b0;
			op_q        <= OP_VT;
			ph_q        <= PH_ABS;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					abg_pkg::REG_SAMPLE_PERIOD:       period_q <= cfg_data;
					abg_pkg::REG_HALF_PERIOD_SQUARED: half_q   <= cfg_data;
					abg_pkg::REG_ALPHA_GAIN:          alpha_q  <= cfg_data;
					abg_pkg::REG_BETA_GAIN:           beta_q   <= cfg_data;
					abg_pkg::REG_ACCEL_GAIN:          accel_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				op_q   <= OP_VT;
				ph_q   <= PH_ABS;
			end else if (busy_q) begin
				case (ph_q)
					PH_ABS: ph_q <= PH_MLO;
					PH_MLO: ph_q <= PH_MHI;
					PH_MHI: ph_q <= PH_SUM;
					PH_SUM: ph_q <= PH_ACC;
					PH_ACC: begin
						if (op_q == OP_VT) begin
							op_q <= OP_AH;
							ph_q <= PH_ABS;
						end else begin
							ph_q <= PH_SAT;
						end
					end
					PH_SAT: begin
						if (op_q == OP_PA) begin
							p_q <= sat_val;
						end
						if (op_q == OP_VB) begin
							v_q <= sat_val;
						end
						if (op_q != OP_AG) begin
							op_q <= op_q + 1'b1;
							ph_q <= PH_ABS;
						end else if (out_free) begin
							busy_q      <= 1'b0;
							op_q        <= OP_VT;
							ph_q        <= PH_ABS;
							out_valid_q <= 1'b1;
							if (last_q) begin
								p_q <= '0;
								v_q <= '0;
								a_q <= '0;
							end else begin
								a_q <= sat_val;
							end
						end
					end
					default: ph_q <= PH_ABS;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample;
			last_q <= last_in_sequence;
			acc_q  <= ACC_W'(p_q);
		end else if (busy_q) begin
			case (ph_q)
				PH_ABS: begin
					opm_q <= src_mag;
					neg_q <= src[MAG_W-1];
				end
				PH_MLO: prod_q <= mul_p;
				PH_MHI: begin
					prod_q <= mul_p;
					part_q <= FULL_W'(prod_q) + ROUND_HALF;
				end
				PH_SUM: mag_q <= mag_next;
				PH_ACC: acc_q <= acc_sum;
				PH_SAT: begin
					case (op_q)
						OP_AH: begin
							pp_q  <= sat_val;
							acc_q <= ACC_W'(v_q);
						end
						OP_AT: begin
							pv_q  <= sat_val;
							r_q   <= r_next;
							acc_q <= ACC_W'(pp_q);
						end
						OP_PA: acc_q <= ACC_W'(pv_q);
						OP_VB: acc_q <= ACC_W'(a_q);
						OP_AG: begin
							if (out_free) begin
								out_q <= p_q;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign in_stall          = busy_q;
	assign out_valid         = out_valid_q;
	assign filtered_position = out_q;

	// The sequencer rests at the first step of the first product whenever it is idle.
	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (op_q == OP_VT && ph_q == PH_ABS))
		else $error("Idle sequencer is not at its first step.");

	// Work on a sample ends only from the final saturate step.
	a_finish_step: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> ($past(op_q) == OP_AG && $past(ph_q) == PH_SAT))
		else $error("Sequencer finished from a step other than the final one.");

	// A new result appears only as the sequencer finishes a sample.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $fell(busy_q))
		else $error("Result register loaded without a finished sample.");

	// The first product chains straight into the second and is never saturated alone.
	a_no_early_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && ph_q == PH_SAT) |-> (op_q != OP_VT))
		else $error("Saturate step reached after the first product.");

	// The end of a sequence leaves all three estimates cleared.
	a_sequence_clear: assert property (@(posedge clk) disable iff (!arst_n)
		($fell(busy_q) && $past(last_q)) |-> (p_q == '0 && v_q == '0 && a_q == '0))
		else $error("Estimates not cleared at the end of a sequence.");

endmodule

@@ verif/tb_alpha_beta_gamma_tracker_unit.sv @@
// Self-checking testbench for the alpha-beta-gamma tracker with its own fixed-point predictor.
`timescale 1ns / 100ps

module tb_alpha_beta_gamma_tracker_unit;

	localparam int VW = abg_pkg::VALUE_WIDTH_DEFAULT;
	localparam int FB = abg_pkg::FRACTION_BITS_DEFAULT;

	typedef logic signed [VW-1:0] value_t;
	typedef logic [abg_pkg::REG_W-1:0] gain_t;

	localparam value_t VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam longint LIMIT_HI = (longint'(1) <<< (VW - 1)) - 1;
	localparam longint LIMIT_LO = -LIMIT_HI - 1;
	localparam logic [63:0] PRODUCT_CAP = 64'd1 << abg_pkg::CAP_LOG2;
	localparam gain_t ONE_Q = gain_t'(1 << FB);
	localparam gain_t HALF_Q = gain_t'(1 << (FB - 1));
	localparam gain_t GAIN_MAX = '1;
	localparam int IDLE_PERCENT = 17;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [abg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [abg_pkg::REG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	value_t sample_data = '0;
	logic end_flag = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	value_t filtered_position;

	gain_t period_q, half_sq_q, alpha_q, beta_q, accel_q;
	longint pos_est, vel_est, acc_est;

	value_t expected_positions[$];
	int error_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int tracks_sent = 0;
	int settings_applied = 0;
	bit allow_idle = 1'b1;
	int hold_request = 0;
	int hold_left = 0;

	alpha_beta_gamma_tracker_unit #(
		.VALUE_WIDTH(VW),
		.FRACTION_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample_data),
		.last_in_sequence(end_flag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_position(filtered_position)
	);

	always #4 clk = ~clk;

	function automatic longint saturate_value(longint x);
		if (x > LIMIT_HI) return LIMIT_HI;
		if (x < LIMIT_LO) return LIMIT_LO;
		return x;
	endfunction

	// Magnitude times gain in two chunks, rounded half away from zero, sign applied last.
	function automatic longint scaled_gain_product(longint v, gain_t g);
		bit neg;
		logic [63:0] m, hi, lo, hp, lp, r;
		neg = v < 0;
		m = neg ? -v : v;
		hi = m >> abg_pkg::CHUNK_W;
		lo = m & ((64'd1 << abg_pkg::CHUNK_W) - 1);
		hp = hi * g;
		lp = lo * g;
		if (hi >= (64'd1 << 36) || (hp >> (36 + FB)) != 0) begin
			r = PRODUCT_CAP;
		end else begin
			r = (hp << (abg_pkg::CHUNK_W - FB)) + ((lp + (64'd1 << (FB - 1))) >> FB);
			if (r > PRODUCT_CAP) r = PRODUCT_CAP;
		end
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic value_t predict_filtered_position(value_t value, bit end_of_track);
		longint x, pp, pv, r;
		value_t result;
		x = value;
		pp = saturate_value(pos_est + scaled_gain_product(vel_est, period_q)
			+ scaled_gain_product(acc_est, half_sq_q));
		pv = saturate_value(vel_est + scaled_gain_product(acc_est, period_q));
		r = x - pp;
		pos_est = saturate_value(pp + scaled_gain_product(r, alpha_q));
		vel_est = saturate_value(pv + scaled_gain_product(r, beta_q));
		acc_est = saturate_value(acc_est + scaled_gain_product(r, accel_q));
		result = value_t'(pos_est);
		if (end_of_track) begin
			pos_est = 0;
			vel_est = 0;
			acc_est = 0;
		end
		return result;
	endfunction

	task automatic write_register(input logic [abg_pkg::CFG_INDEX_W-1:0] idx, input gain_t data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			abg_pkg::REG_SAMPLE_PERIOD: period_q = data;
			abg_pkg::REG_HALF_PERIOD_SQUARED: half_sq_q = data;
			abg_pkg::REG_ALPHA_GAIN: alpha_q = data;
			abg_pkg::REG_BETA_GAIN: beta_q = data;
			abg_pkg::REG_ACCEL_GAIN: accel_q = data;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input gain_t t, input gain_t half_sq, input gain_t a,
			input gain_t b, input gain_t g);
		write_register(abg_pkg::REG_SAMPLE_PERIOD, t);
		write_register(abg_pkg::REG_HALF_PERIOD_SQUARED, half_sq);
		write_register(abg_pkg::REG_ALPHA_GAIN, a);
		write_register(abg_pkg::REG_BETA_GAIN, b);
		write_register(abg_pkg::REG_ACCEL_GAIN, g);
		settings_applied++;
	endtask

	task automatic apply_random_settings();
		gain_t t;
		if ($urandom_range(0, 3) == 0) begin
			apply_settings(gain_t'($urandom), gain_t'($urandom), gain_t'($urandom),
				gain_t'($urandom), gain_t'($urandom));
		end else begin
			t = gain_t'($urandom_range(1 << 12, 1 << 18));
			apply_settings(t, gain_t'((longint'(t) * t) >> (FB + 1)),
				gain_t'($urandom_range(1 << 13, 1 << 16)),
				gain_t'($urandom_range(1 << 8, 1 << 15)),
				gain_t'($urandom_range(0, 1 << 13)));
		end
	endtask

	// The valid stays high after a transfer so that a following sample is offered
	// without a gap; callers that pause go through wait_until_drained.
	task automatic send_sample(input value_t value, input bit end_of_track);
		while (allow_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_data <= value;
		end_flag <= end_of_track;
		do @(posedge clk); while (in_stall);
		expected_positions.push_back(predict_filtered_position(value, end_of_track));
		samples_sent++;
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A smooth trajectory with measurement noise, or else raw noise with random ends.
	task automatic run_track(input bit noisy);
		int len;
		longint pos, vel, acc, amp;
		len = $urandom_range(4, 40);
		if (noisy) begin
			for (int i = 0; i < len; i++)
				send_sample(value_t'($urandom), $urandom_range(0, 7) == 0);
		end else begin
			pos = longint'($signed($urandom)) >>> $urandom_range(0, 8);
			vel = longint'($signed($urandom)) >>> $urandom_range(8, 20);
			acc = longint'($signed($urandom)) >>> $urandom_range(14, 28);
			amp = $urandom_range(0, 1 << FB);
			for (int i = 0; i < len; i++) begin
				send_sample(value_t'(saturate_value(pos + longint'($urandom_range(0, int'(2 * amp)))
					- amp)), i == len - 1);
				pos += vel;
				vel += acc;
			end
		end
		tracks_sent++;
	endtask

	task automatic run_tracks(input int count);
		int target;
		target = samples_sent + count;
		while (samples_sent < target) run_track($urandom_range(0, 4) == 0);
	endtask

	task automatic test_reset_state();
		send_sample(VALUE_MAX, 1'b0);
		send_sample(VALUE_MIN, 1'b1);
		wait_until_drained();
		for (int idx = abg_pkg::REG_ACCEL_GAIN + 1; idx < (1 << abg_pkg::CFG_INDEX_W); idx++)
			write_register(abg_pkg::CFG_INDEX_W'(idx), GAIN_MAX);
		send_sample(value_t'(-1), 1'b1);
	endtask

	task automatic test_directed_extremes();
		wait_until_drained();
		apply_settings(ONE_Q, HALF_Q, ONE_Q, HALF_Q, gain_t'(1 << (FB - 4)));
		send_sample(value_t'(0), 1'b0);
		send_sample(value_t'(1), 1'b0);
		send_sample(value_t'(-1), 1'b0);
		send_sample(VALUE_MAX, 1'b0);
		send_sample(VALUE_MAX, 1'b0);
		send_sample(VALUE_MIN, 1'b0);
		send_sample(VALUE_MIN, 1'b1);
		send_sample(value_t'(32'h1234_5678), 1'b1);
		wait_until_drained();
		apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
		send_sample(VALUE_MAX, 1'b0);
		send_sample(VALUE_MIN, 1'b0);
		send_sample(VALUE_MAX, 1'b0);
		send_sample(value_t'(1), 1'b0);
		send_sample(value_t'(-1), 1'b1);
		wait_until_drained();
		apply_settings(HALF_Q, HALF_Q, HALF_Q, HALF_Q, gain_t'(0));
		send_sample(value_t'(1), 1'b0);
		send_sample(value_t'(-1), 1'b0);
		send_sample(value_t'(3), 1'b1);
		wait_until_drained();
		apply_settings(gain_t'(0), gain_t'(0), gain_t'(0), gain_t'(0), gain_t'(0));
		send_sample(VALUE_MAX, 1'b0);
		send_sample(value_t'(-1), 1'b1);
	endtask

	task automatic test_random_tracks();
		repeat (9) begin
			wait_until_drained();
			apply_random_settings();
			run_tracks(45);
		end
	endtask

	// The receiver holds off long enough for the block to fill up and stall its input.
	task automatic test_output_backpressure();
		wait_until_drained();
		apply_settings(ONE_Q, HALF_Q, HALF_Q, gain_t'(1 << (FB - 2)), gain_t'(1 << (FB - 5)));
		hold_request = 400;
		run_tracks(40);
		wait_until_drained();
		run_tracks(10);
	endtask

	task automatic test_back_to_back();
		wait_until_drained();
		apply_random_settings();
		allow_idle = 1'b0;
		run_tracks(80);
		allow_idle = 1'b1;
	endtask

	initial begin
		value_t wanted;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_positions.size() == 0) begin
					$display("%0t: unexpected filtered_position %0d, expected none", $time,
						filtered_position);
					error_count++;
				end else begin
					wanted = expected_positions.pop_front();
					results_checked++;
					if (filtered_position !== wanted) begin
						$display("%0t: filtered_position mismatch, expected %0d, actual %0d",
							$time, wanted, filtered_position);
						error_count++;
					end
				end
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= allow_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	initial begin
		period_q = ONE_Q;
		half_sq_q = HALF_Q;
		alpha_q = '0;
		beta_q = '0;
		accel_q = '0;
		pos_est = 0;
		vel_est = 0;
		acc_est = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_extremes();
		test_random_tracks();
		test_output_backpressure();
		test_back_to_back();
		wait_until_drained();
		repeat (40) @(posedge clk);
		$display("Covered %0d samples in %0d generated tracks under %0d register settings.",
			samples_sent, tracks_sent, settings_applied);
		$display("Checked %0d filtered positions, including a long output hold-off.",
			results_checked);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
